>>> src/svm_pkg.sv
// ----------------------------------------------------------------------------
// svm_pkg: shared types and constants of the sample voice mixer
// Mode codes, sizes and the voice record kept in the voice memory.
// ----------------------------------------------------------------------------
package svm_pkg;

   localparam int TRACKS           = 8;
   localparam int VOICES_PER_GROUP = 2;
   localparam int VOICES           = TRACKS * VOICES_PER_GROUP;
   localparam int TRACK_W          = 3;
   localparam int VOICE_W          = 4;
   localparam int GROUP_W          = 1;
   localparam int ADDR_W           = 16;
   localparam int COUNT_W          = 5;

   localparam logic signed [15:0] MASTER_RESET = 16'sh4000;
   localparam logic [23:0]        STEP_RESET   = 24'h010000;
   localparam logic signed [15:0] GAIN_RESET   = 16'sh7FFF;

   typedef enum logic [2:0] {
      MODE_TICK    = 3'd0,
      MODE_TRIGGER = 3'd1,
      MODE_STOP    = 3'd2,
      MODE_STOPALL = 3'd3,
      MODE_SAMPLE  = 3'd4,
      MODE_PITCH   = 3'd5,
      MODE_GAIN    = 3'd6,
      MODE_WRITE   = 3'd7
   } mode_type;

   // Per-voice record held in the voice memory (busy kept in flops).
   typedef struct packed {
      logic [15:0]        start;
      logic [15:0]        length;
      logic [31:0]        phase;
      logic [23:0]        step;
      logic signed [15:0] gain;
      logic [31:0]        age;
   } voice_type;

   // Mix request from the sequencer to the datapath for one voice.
   typedef struct packed {
      logic               first;
      logic               last;
      logic               play;
   } mix_ctl_type;

endpackage

>>> src/sample_voice_mixer_top.sv
// Control items go back to idle once their state steps are done. A tick
// puts out its result once all voices are mixed, and only then is the next
// item taken. Each voice goes through the record read and two sample word
// reads through the one sample memory port, then the mix step. The closing
// states drain the mixer and apply the master gain. One item is in work at
// a time. A result held by rsp_stall holds only the next tick's output
// step.
// Reset is synchronous; voice busy bits, track settings and master level
// return to their defaults at once. The sample store is not cleared.
// ----------------------------------------------------------------------------
// sample_voice_mixer_top: polyphonic sample player and mixer
// Sequences voices through the voice memory, fetches samples and mixes.
// ----------------------------------------------------------------------------
module sample_voice_mixer_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic signed [15:0] csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic [2:0]         req_track,
   input  logic [15:0]        req_address,
   input  logic [15:0]        req_length,
   input  logic [23:0]        req_pitch_step,
   input  logic signed [15:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample,
   output logic [7:0]         rsp_active_tracks,
   output logic [4:0]         rsp_active_voices
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_TRIG_RD, ST_TRIG_CHK, ST_TRIG_WR, ST_PITCH,
      ST_TK_RD, ST_TK_A, ST_TK_B, ST_TK_NEXT, ST_FIN1, ST_FIN2, ST_FIN3, ST_OUT
   } state_type;

   state_type state_ff;
   logic [2:0]  mode_ff;
   logic [2:0]  track_ff;
   logic [23:0] step_ff;
   logic [svm_pkg::VOICE_W-1:0] v_ff;
   logic [svm_pkg::GROUP_W:0]   g_ff;
   logic [svm_pkg::VOICE_W-1:0] pick_ff;
   logic        found_ff;
   logic [31:0] best_ff;
   logic [31:0] trig_cnt_ff;
   logic [svm_pkg::VOICES-1:0] busy_ff;
   logic [svm_pkg::TRACKS-1:0] tvalid_ff;
   logic [15:0] tstart_ff  [svm_pkg::TRACKS];
   logic [15:0] tlen_ff    [svm_pkg::TRACKS];
   logic [23:0] tstep_ff   [svm_pkg::TRACKS];
   logic signed [15:0] tgain_ff [svm_pkg::TRACKS];
   logic signed [15:0] master_ff;
   logic [7:0]  mask_ff;
   logic [4:0]  count_ff;
   svm_pkg::voice_type cur_ff;
   logic signed [15:0] a_ff;
   logic        rsp_valid_ff;
   logic signed [15:0] rsp_sample_ff;
   logic [7:0]  rsp_tracks_ff;
   logic [4:0]  rsp_voices_ff;
   logic signed [41:0] master_prod_ff;

   logic        vr_we;
   logic [svm_pkg::VOICE_W-1:0] vr_wa, vr_ra;
   svm_pkg::voice_type vr_wd, vr_rd;
   logic        sr_we;
   logic [15:0] sr_ra;
   logic signed [15:0] sr_rd;
   svm_pkg::mix_ctl_type mctl;
   logic signed [24:0] mix_sum;
   logic        mix_done;
   logic [svm_pkg::VOICE_W-1:0] vidx;
   logic [31:0] limit;
   logic signed [41:0] clip_src;

   assign vidx = svm_pkg::VOICE_W'({track_ff, g_ff[svm_pkg::GROUP_W-1:0]});
   assign limit = {16'(cur_ff.length - 16'd1), 16'd0};
   assign clip_src = master_prod_ff >>> 15;

   svm_voice_ram u_voice (
      .clock(clock), .wr_en(vr_we), .wr_addr(vr_wa), .wr_data(vr_wd),
      .rd_addr(vr_ra), .rd_data(vr_rd)
   );

   svm_sample_ram u_sample (
      .clock(clock), .wr_en(sr_we), .wr_addr(req_address), .wr_data(req_value),
      .rd_addr(sr_ra), .rd_data(sr_rd)
   );

   svm_mix u_mix (
      .clock(clock), .reset(reset), .ctl(mctl), .word_a(a_ff), .word_b(sr_rd),
      .frac(cur_ff.phase[15:8]), .gain(cur_ff.gain), .sum(mix_sum),
      .sum_done(mix_done)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign sr_we = req_valid && !req_stall
               && (req_mode == svm_pkg::MODE_WRITE);

   always_comb begin
      vr_we = 1'b0;
      vr_wa = v_ff;
      vr_wd = cur_ff;
      vr_ra = v_ff;
      sr_ra = cur_ff.start + cur_ff.phase[31:16];
      mctl  = '0;
      case (state_ff)
         ST_TRIG_RD: vr_ra = vidx;
         ST_TRIG_WR: begin
            vr_we = 1'b1;
            vr_wa = pick_ff;
            vr_wd.start  = tstart_ff[track_ff];
            vr_wd.length = tlen_ff[track_ff];
            vr_wd.phase  = '0;
            vr_wd.step   = tstep_ff[track_ff];
            vr_wd.gain   = tgain_ff[track_ff];
            vr_wd.age    = trig_cnt_ff + 32'd1;
         end
         ST_PITCH: begin
            vr_we = 1'b1;
            vr_wa = vidx;
            vr_wd = vr_rd;
            vr_wd.step = step_ff;
         end
         ST_TK_A: begin
            // record is still on the read port, cur_ff loads at this edge
            sr_ra = vr_rd.start + vr_rd.phase[31:16];
         end
         ST_TK_B: begin
            sr_ra = cur_ff.start + cur_ff.phase[31:16] + 16'd1;
         end
         ST_TK_NEXT: begin
            mctl.first = (v_ff == '0);
            mctl.play  = busy_ff[v_ff] && (cur_ff.phase < limit);
            mctl.last  = (v_ff == svm_pkg::VOICE_W'(svm_pkg::VOICES - 1));
            vr_we = mctl.play;
            vr_wd.phase = cur_ff.phase + 32'(cur_ff.step);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         busy_ff     <= '0;
         tvalid_ff   <= '0;
         trig_cnt_ff <= '0;
         master_ff   <= svm_pkg::MASTER_RESET;
         rsp_valid_ff <= 1'b0;
         for (int t = 0; t < svm_pkg::TRACKS; t++) begin
            tstart_ff[t] <= '0;
            tlen_ff[t]   <= '0;
            tstep_ff[t]  <= svm_pkg::STEP_RESET;
            tgain_ff[t]  <= svm_pkg::GAIN_RESET;
         end
      end else begin
         if (csr_write) begin
            master_ff <= csr_data;
         end
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && !req_stall) begin
                  mode_ff  <= req_mode;
                  track_ff <= req_track;
                  step_ff  <= req_pitch_step;
                  g_ff     <= '0;
                  v_ff     <= '0;
                  found_ff <= 1'b0;
                  best_ff  <= '1;
                  pick_ff  <= {req_track, {svm_pkg::GROUP_W{1'b0}}};
                  mask_ff  <= '0;
                  count_ff <= '0;
                  case (svm_pkg::mode_type'(req_mode))
                     svm_pkg::MODE_TICK: state_ff <= ST_TK_RD;
                     svm_pkg::MODE_TRIGGER: begin
                        if (tvalid_ff[req_track]) state_ff <= ST_TRIG_RD;
                     end
                     svm_pkg::MODE_STOP: begin
                        for (int k = 0; k < svm_pkg::VOICES_PER_GROUP; k++)
                           busy_ff[{req_track, svm_pkg::GROUP_W'(k)}] <= 1'b0;
                     end
                     svm_pkg::MODE_STOPALL: busy_ff <= '0;
                     svm_pkg::MODE_SAMPLE: begin
                        for (int k = 0; k < svm_pkg::VOICES_PER_GROUP; k++)
                           busy_ff[{req_track, svm_pkg::GROUP_W'(k)}] <= 1'b0;
                        tvalid_ff[req_track] <= (req_length >= 16'd2);
                        tstart_ff[req_track] <= req_address;
                        tlen_ff[req_track]   <= req_length;
                     end
                     svm_pkg::MODE_PITCH: begin
                        if (req_pitch_step != '0) begin
                           tstep_ff[req_track] <= req_pitch_step;
                           state_ff <= ST_TRIG_RD;
                        end
                     end
                     svm_pkg::MODE_GAIN: tgain_ff[req_track] <= req_value;
                     default: ;
                  endcase
               end
            end
            ST_TRIG_RD: state_ff <= (mode_ff == svm_pkg::MODE_PITCH) ? ST_PITCH
                                                                   : ST_TRIG_CHK;
            ST_PITCH: begin
               // read-modify-write one group member at a time, through ST_TRIG_RD and ST_PITCH
               if (g_ff == (svm_pkg::GROUP_W+1)'(svm_pkg::VOICES_PER_GROUP - 1)) begin
                  state_ff <= ST_IDLE;
               end else begin
                  g_ff <= g_ff + 1'b1;
                  state_ff <= ST_TRIG_RD;
               end
            end
            ST_TRIG_CHK: begin
               if (!found_ff) begin
                  if (!busy_ff[vidx]) begin
                     found_ff <= 1'b1;
                     pick_ff  <= vidx;
                  end else if (vr_rd.age < best_ff) begin
                     best_ff <= vr_rd.age;
                     pick_ff <= vidx;
                  end
               end
               if (g_ff == (svm_pkg::GROUP_W+1)'(svm_pkg::VOICES_PER_GROUP - 1)) begin
                  state_ff <= ST_TRIG_WR;
               end else begin
                  g_ff <= g_ff + 1'b1;
                  state_ff <= ST_TRIG_RD;
               end
            end
            ST_TRIG_WR: begin
               trig_cnt_ff <= trig_cnt_ff + 32'd1;
               busy_ff[pick_ff] <= 1'b1;
               state_ff <= ST_IDLE;
            end
            ST_TK_RD: state_ff <= ST_TK_A;
            ST_TK_A: begin
               cur_ff <= vr_rd;
               state_ff <= ST_TK_B;
            end
            ST_TK_B: begin
               a_ff <= sr_rd;
               state_ff <= ST_TK_NEXT;
            end
            ST_TK_NEXT: begin
               if (busy_ff[v_ff]) begin
                  count_ff <= count_ff + 5'd1;
                  mask_ff[v_ff[svm_pkg::VOICE_W-1:svm_pkg::GROUP_W]] <= 1'b1;
                  if (!(cur_ff.phase < limit)) busy_ff[v_ff] <= 1'b0;
               end
               if (v_ff == svm_pkg::VOICE_W'(svm_pkg::VOICES - 1)) begin
                  state_ff <= ST_FIN1;
               end else begin
                  v_ff <= v_ff + 1'b1;
                  state_ff <= ST_TK_RD;
               end
            end
            ST_FIN1: state_ff <= ST_FIN2;
            ST_FIN2: begin
               if (mix_done) state_ff <= ST_FIN3;
            end
            ST_FIN3: begin
               master_prod_ff <= 42'(mix_sum) * 42'(master_ff);
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               // hold while the previous beat is still stalled
               if (!rsp_valid_ff || !rsp_stall) begin
                  if (clip_src > 42'sd32767) rsp_sample_ff <= 16'sh7FFF;
                  else if (clip_src < -42'sd32768) rsp_sample_ff <= -16'sh8000;
                  else rsp_sample_ff <= 16'(clip_src);
                  rsp_tracks_ff <= mask_ff;
                  rsp_voices_ff <= count_ff;
                  rsp_valid_ff  <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample        = rsp_sample_ff;
   assign rsp_active_tracks = rsp_tracks_ff;
   assign rsp_active_voices = rsp_voices_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("item accepted while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_sample)))
      else $error("result dropped while stalled");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_active_voices <= 5'(svm_pkg::VOICES)))
      else $error("voice count out of range");

endmodule

>>> src/svm_voice_ram.sv
// ----------------------------------------------------------------------------
// svm_voice_ram: voice record memory
// One write and one registered read port, one record per voice.
// ----------------------------------------------------------------------------
module svm_voice_ram (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [svm_pkg::VOICE_W-1:0]  wr_addr,
   input  svm_pkg::voice_type           wr_data,
   input  logic [svm_pkg::VOICE_W-1:0]  rd_addr,
   output svm_pkg::voice_type           rd_data
);

   svm_pkg::voice_type mem [svm_pkg::VOICES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> src/svm_sample_ram.sv
// ----------------------------------------------------------------------------
// svm_sample_ram: sample word store
// One write port and one registered read port; contents undefined at reset.
// ----------------------------------------------------------------------------
module svm_sample_ram (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [svm_pkg::ADDR_W-1:0]  wr_addr,
   input  logic signed [15:0]          wr_data,
   input  logic [svm_pkg::ADDR_W-1:0]  rd_addr,
   output logic signed [15:0]          rd_data
);

   logic signed [15:0] mem [2**svm_pkg::ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> src/svm_mix.sv
// ----------------------------------------------------------------------------
// svm_mix: interpolate, voice gain and accumulate
// Takes both sample words of one voice and adds its scaled value to the sum.
// ----------------------------------------------------------------------------
module svm_mix (
   input  logic                  clock,
   input  logic                  reset,
   input  svm_pkg::mix_ctl_type  ctl,
   input  logic signed [15:0]    word_a,
   input  logic signed [15:0]    word_b,
   input  logic [7:0]            frac,
   input  logic signed [15:0]    gain,
   output logic signed [24:0]    sum,
   output logic                  sum_done
);

   logic signed [24:0] x_ff, x_in;
   logic signed [15:0] g_ff;
   logic               ctl_play_ff, ctl_last_ff, ctl_first_ff;
   logic signed [24:0] acc_ff, acc_in;
   logic               done_ff;
   logic signed [16:0] diff;
   logic signed [25:0] prod;
   logic signed [41:0] scaled;

   always_comb begin
      diff   = 17'(word_b) - 17'(word_a);
      prod   = 26'(diff) * 26'($signed({1'b0, frac}));
      x_in   = 25'(word_a) + 25'(prod >>> 8);
      scaled = 42'(x_ff) * 42'(g_ff);
      acc_in = (ctl_first_ff ? 25'sd0 : acc_ff)
             + (ctl_play_ff ? 25'(scaled >>> 15) : 25'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_play_ff  <= 1'b0;
         ctl_last_ff  <= 1'b0;
         ctl_first_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         ctl_play_ff  <= ctl.play;
         ctl_last_ff  <= ctl.last;
         ctl_first_ff <= ctl.first;
         done_ff      <= ctl_last_ff;
      end
      x_ff <= x_in;
      g_ff <= gain;
      if (ctl_first_ff || ctl_play_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign sum      = acc_ff;
   assign sum_done = done_ff;

endmodule

>>> test/tb_sample_voice_mixer_top.sv
// ----------------------------------------------------------------------------
// tb_sample_voice_mixer_top: self-checking bench for the sample voice mixer
// A directed command table, then random command streams across several master
// levels, all checked frame by frame against an in-bench mixer predictor.
// ----------------------------------------------------------------------------
module tb_sample_voice_mixer_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 80;
   localparam int RANDOM_ITEMS   = 2000;
   localparam int PHASES         = 5;

   typedef struct {
      svm_pkg::mode_type  mode;
      logic [2:0]         track;
      logic [15:0]        address;
      logic [15:0]        length;
      logic [23:0]        step;
      logic signed [15:0] value;
   } command_type;

   typedef struct {
      logic signed [15:0] sample;
      logic [7:0]         tracks;
      logic [4:0]         voices;
   } frame_type;

   typedef struct {
      command_type cmd;
      bit          typed;
      frame_type   frame;
   } row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write = 1'b0;
   logic signed [15:0] csr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_mode = '0;
   logic [2:0]         req_track = '0;
   logic [15:0]        req_address = '0;
   logic [15:0]        req_length = '0;
   logic [23:0]        req_pitch_step = '0;
   logic signed [15:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_sample;
   logic [7:0]         rsp_active_tracks;
   logic [4:0]         rsp_active_voices;

   sample_voice_mixer_top dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_track(req_track), .req_address(req_address), .req_length(req_length),
      .req_pitch_step(req_pitch_step), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_sample(rsp_sample),
      .rsp_active_tracks(rsp_active_tracks), .rsp_active_voices(rsp_active_voices)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mixer state mirror
   logic signed [15:0] master;
   bit                 v_busy [svm_pkg::VOICES];
   int unsigned        v_start [svm_pkg::VOICES];
   int unsigned        v_len [svm_pkg::VOICES];
   int unsigned        v_phase [svm_pkg::VOICES];
   int unsigned        v_step [svm_pkg::VOICES];
   longint             v_gain [svm_pkg::VOICES];
   int unsigned        v_age [svm_pkg::VOICES];
   int unsigned        trig_count;
   bit                 t_valid [svm_pkg::TRACKS];
   int unsigned        t_start [svm_pkg::TRACKS];
   int unsigned        t_len [svm_pkg::TRACKS];
   int unsigned        t_step [svm_pkg::TRACKS];
   logic signed [15:0] t_gain [svm_pkg::TRACKS];
   logic signed [15:0] store [65536];
   bit                 written [65536];

   frame_type pending_frames [$];
   int     errors = 0;
   int     frames_checked = 0;
   int     triggers_sent = 0;
   bit     quiet_sender = 1'b0;

   function automatic void reset_mirror();
      master = svm_pkg::MASTER_RESET;
      trig_count = 0;
      for (int v = 0; v < svm_pkg::VOICES; v++) begin
         v_busy[v] = 0; v_start[v] = 0; v_len[v] = 0; v_phase[v] = 0;
         v_step[v] = 0; v_gain[v] = 0; v_age[v] = 0;
      end
      for (int t = 0; t < svm_pkg::TRACKS; t++) begin
         t_valid[t] = 0; t_start[t] = 0; t_len[t] = 0;
         t_step[t] = svm_pkg::STEP_RESET; t_gain[t] = svm_pkg::GAIN_RESET;
      end
   endfunction

   function automatic longint fetch_word(int unsigned addr);
      return longint'(store[16'(addr)]);
   endfunction

   function automatic frame_type mix_frame();
      frame_type   f;
      longint      acc, s, a, b, x, fr;
      int unsigned lim, idx, ph;
      int          cnt;
      logic [7:0]  mask;
      acc = 0; cnt = 0; mask = '0;
      for (int v = 0; v < svm_pkg::VOICES; v++) begin
         if (!v_busy[v]) continue;
         cnt++;
         mask[v / svm_pkg::VOICES_PER_GROUP] = 1'b1;
         ph = v_phase[v];
         lim = (v_len[v] - 32'd1) << 16;
         if (ph >= lim) begin
            v_busy[v] = 0;
            continue;
         end
         idx = ph >> 16;
         fr = longint'((ph >> 8) & 32'hFF);
         a = fetch_word(v_start[v] + idx);
         b = fetch_word(v_start[v] + idx + 1);
         x = a + (((b - a) * fr) >>> 8);
         acc += (x * v_gain[v]) >>> 15;
         v_phase[v] = ph + v_step[v];
      end
      s = (acc * longint'(master)) >>> 15;
      if (s > 32767) s = 32767;
      else if (s < -32768) s = -32768;
      f.sample = 16'(s);
      f.tracks = mask;
      f.voices = 5'(cnt);
      return f;
   endfunction

   function automatic void start_voice(int t);
      int          base, pick;
      int unsigned oldest;
      base = t * svm_pkg::VOICES_PER_GROUP;
      pick = base;
      oldest = 32'hFFFF_FFFF;
      if (!t_valid[t] || t_len[t] < 2) return;
      for (int v = 0; v < svm_pkg::VOICES_PER_GROUP; v++) begin
         if (!v_busy[base + v]) begin
            pick = base + v;
            break;
         end
         if (v_age[base + v] < oldest) begin
            oldest = v_age[base + v];
            pick = base + v;
         end
      end
      trig_count++;
      v_busy[pick] = 1; v_start[pick] = t_start[t]; v_len[pick] = t_len[t];
      v_phase[pick] = 0; v_step[pick] = t_step[t];
      v_gain[pick] = longint'(t_gain[t]); v_age[pick] = trig_count;
   endfunction

   // Advance the mirror by one command; returns 1 when a frame is due.
   function automatic bit apply_command(command_type c, output frame_type f);
      int t;
      t = c.track;
      f = '{default: '0};
      case (c.mode)
         svm_pkg::MODE_TICK: begin
            f = mix_frame();
            return 1;
         end
         svm_pkg::MODE_TRIGGER: start_voice(t);
         svm_pkg::MODE_STOP:
            for (int v = 0; v < svm_pkg::VOICES_PER_GROUP; v++)
               v_busy[t * svm_pkg::VOICES_PER_GROUP + v] = 0;
         svm_pkg::MODE_STOPALL:
            for (int v = 0; v < svm_pkg::VOICES; v++) v_busy[v] = 0;
         svm_pkg::MODE_SAMPLE: begin
            for (int v = 0; v < svm_pkg::VOICES_PER_GROUP; v++)
               v_busy[t * svm_pkg::VOICES_PER_GROUP + v] = 0;
            t_valid[t] = c.length >= 2;
            t_start[t] = c.address;
            t_len[t] = c.length;
         end
         svm_pkg::MODE_PITCH:
            if (c.step != 0) begin
               t_step[t] = c.step;
               for (int v = 0; v < svm_pkg::VOICES_PER_GROUP; v++)
                  v_step[t * svm_pkg::VOICES_PER_GROUP + v] = c.step;
            end
         svm_pkg::MODE_GAIN: t_gain[t] = c.value;
         default: begin
            store[c.address] = c.value;
            written[c.address] = 1;
         end
      endcase
      return 0;
   endfunction

   // First unwritten word that a trigger of track t would read, or -1.
   function automatic int first_gap(int t);
      for (int unsigned i = 0; i < t_len[t]; i++)
         if (!written[16'(t_start[t] + i)]) return int'(16'(t_start[t] + i));
      return -1;
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet_sender) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   function automatic command_type make_command(svm_pkg::mode_type m, int t, int addr,
                                                int len, int step, int val);
      command_type c;
      c.mode = m; c.track = 3'(t); c.address = 16'(addr); c.length = 16'(len);
      c.step = 24'(step); c.value = 16'(val);
      return c;
   endfunction

   function automatic int window_addr();
      if ($urandom_range(0, 9) < 7) return 16'(16'hFF80 + $urandom_range(0, 511));
      return $urandom_range(0, 65535);
   endfunction

   function automatic command_type random_command();
      command_type c;
      int          r, t, gap;
      c = make_command(svm_pkg::MODE_TICK, $urandom_range(0, 7), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 24'hFFFFFF),
                       $urandom_range(0, 65535));
      t = c.track;
      r = $urandom_range(0, 99);
      if (r < 40) c.mode = svm_pkg::MODE_TICK;
      else if (r < 55) c.mode = svm_pkg::MODE_TRIGGER;
      else if (r < 70) begin
         c.mode = svm_pkg::MODE_WRITE;
         c.address = 16'(window_addr());
      end else if (r < 78) begin
         c.mode = svm_pkg::MODE_SAMPLE;
         c.address = 16'(16'hFF80 + $urandom_range(0, 400));
         r = $urandom_range(0, 9);
         if (r < 8) c.length = 16'($urandom_range(2, 32));
         else if (r < 9) c.length = 16'($urandom_range(0, 1));
         if ($urandom_range(0, 19) == 0) c.address = 16'($urandom_range(0, 65535));
      end else if (r < 86) begin
         c.mode = svm_pkg::MODE_PITCH;
         r = $urandom_range(0, 9);
         if (r < 7) c.step = 24'($urandom_range(24'h002000, 24'h030000));
         else if (r < 8) c.step = '0;
      end else if (r < 93) c.mode = svm_pkg::MODE_GAIN;
      else if (r < 98) c.mode = svm_pkg::MODE_STOP;
      else c.mode = svm_pkg::MODE_STOPALL;
      // fill the sample before playing it
      if (c.mode == svm_pkg::MODE_TRIGGER && t_valid[t]) begin
         gap = first_gap(t);
         if (gap >= 0) begin
            c.mode = svm_pkg::MODE_WRITE;
            c.address = 16'(gap);
         end
      end
      return c;
   endfunction

   // Drive one beat from a falling edge, return at a falling edge.
   task automatic send_beat(command_type c, bit typed, frame_type typed_frame);
      frame_type f;
      int        gap;
      req_mode <= c.mode; req_track <= c.track; req_address <= c.address;
      req_length <= c.length; req_pitch_step <= c.step; req_value <= c.value;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (c.mode == svm_pkg::MODE_TRIGGER) triggers_sent++;
      if (apply_command(c, f)) pending_frames.push_back(typed ? typed_frame : f);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic write_master(logic signed [15:0] level);
      req_valid <= 1'b0;
      wait (pending_frames.size() == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write <= 1'b1;
      csr_data <= level;
      @(negedge clock);
      csr_write <= 1'b0;
      master = level;
   endtask

   // response checking
   always @(posedge clock) begin
      frame_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_frames.size() == 0) begin
            $error("frame with no expectation: sample %0d", rsp_sample);
            errors++;
         end else begin
            want = pending_frames.pop_front();
            frames_checked++;
            if (rsp_sample !== want.sample) begin
               $error("sample: expected %0d, got %0d", want.sample, rsp_sample);
               errors++;
            end
            if (rsp_active_tracks !== want.tracks) begin
               $error("active_tracks: expected %h, got %h", want.tracks, rsp_active_tracks);
               errors++;
            end
            if (rsp_active_voices !== want.voices) begin
               $error("active_voices: expected %0d, got %0d", want.voices, rsp_active_voices);
               errors++;
            end
         end
      end
   end

   // receiver back-pressure: bursts of stall, some long open stretches
   initial begin
      int r;
      forever begin
         rsp_stall <= 1'b0;
         r = $urandom_range(0, 9);
         repeat (r < 2 ? $urandom_range(100, 300) : $urandom_range(1, 8)) @(negedge clock);
         rsp_stall <= 1'b1;
         r = $urandom_range(0, 9);
         repeat (r < 8 ? $urandom_range(1, 3) : $urandom_range(5, 40)) @(negedge clock);
      end
   end

   // watchdog: no beat on either side for too long
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
         if (idle >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   row_type directed [$];

   initial begin
      frame_type none, zero;
      logic signed [15:0] levels [PHASES];
      none = '{default: '0};
      zero = '{default: '0};
      levels = '{16'sh7FFF, -16'sd32768, 16'sd0, 16'sh4000, 16'sh0000};
      levels[4] = 16'($urandom_range(0, 65535));
      reset_mirror();
      directed = '{
         '{make_command(svm_pkg::MODE_TICK, 0, 0, 0, 0, 0), 1, zero},
         '{make_command(svm_pkg::MODE_WRITE, 0, 16'hFFFF, 0, 0, 32767), 0, none},
         '{make_command(svm_pkg::MODE_WRITE, 0, 16'h0000, 0, 0, -32768), 0, none},
         '{make_command(svm_pkg::MODE_WRITE, 0, 16'h0001, 0, 0, 32767), 0, none},
         '{make_command(svm_pkg::MODE_SAMPLE, 7, 16'hFFFF, 3, 0, 0), 0, none},
         '{make_command(svm_pkg::MODE_GAIN, 7, 0, 0, 0, 32767), 0, none},
         '{make_command(svm_pkg::MODE_PITCH, 7, 0, 0, 24'h008000, 0), 0, none},
         '{make_command(svm_pkg::MODE_PITCH, 7, 0, 0, 0, 0), 0, none},
         '{make_command(svm_pkg::MODE_TRIGGER, 7, 0, 0, 0, 0), 0, none},
         '{make_command(svm_pkg::MODE_TRIGGER, 7, 0, 0, 0, 0), 0, none},
         '{make_command(svm_pkg::MODE_TRIGGER, 7, 0, 0, 0, 0), 0, none},
         '{make_command(svm_pkg::MODE_TICK, 0, 0, 0, 0, 0), 0, none},
         '{make_command(svm_pkg::MODE_TICK, 0, 0, 0, 0, 0), 0, none},
         '{make_command(svm_pkg::MODE_GAIN, 0, 0, 0, 0, -32768), 0, none},
         '{make_command(svm_pkg::MODE_SAMPLE, 0, 16'h0000, 2, 0, 0), 0, none},
         '{make_command(svm_pkg::MODE_TRIGGER, 0, 0, 0, 0, 0), 0, none},
         '{make_command(svm_pkg::MODE_TICK, 0, 0, 0, 0, 0), 0, none},
         '{make_command(svm_pkg::MODE_SAMPLE, 1, 16'h0000, 1, 0, 0), 0, none},
         '{make_command(svm_pkg::MODE_TRIGGER, 1, 0, 0, 0, 0), 0, none},
         '{make_command(svm_pkg::MODE_PITCH, 3, 0, 0, 24'hFFFFFF, 0), 0, none},
         '{make_command(svm_pkg::MODE_STOP, 7, 0, 0, 0, 0), 0, none},
         '{make_command(svm_pkg::MODE_TICK, 0, 0, 0, 0, 0), 0, none},
         '{make_command(svm_pkg::MODE_STOPALL, 0, 0, 0, 0, 0), 0, none},
         '{make_command(svm_pkg::MODE_TICK, 0, 0, 0, 0, 0), 1, zero},
         '{make_command(svm_pkg::MODE_SAMPLE, 2, 16'hFFFF, 16'hFFFF, 0, 0), 0, none}
      };
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed[i]) send_beat(directed[i].cmd, directed[i].typed, directed[i].frame);
      for (int p = 0; p < PHASES; p++) begin
         write_master(levels[p]);
         for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
            if (i % 100 == 0) quiet_sender = $urandom_range(0, 3) == 0;
            send_beat(random_command(), 0, none);
         end
      end
      req_valid <= 1'b0;
      wait (pending_frames.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d checked frames, %0d triggers, %0d master levels.",
               frames_checked, triggers_sent, PHASES + 1);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> sim.f
src/svm_pkg.sv
src/svm_voice_ram.sv
src/svm_sample_ram.sv
src/svm_mix.sv
src/sample_voice_mixer_top.sv
test/tb_sample_voice_mixer_top.sv
